FILE: src/cpfm_pkg.sv
package cpfm_pkg;

    localparam int ChanW     = 2;
    localparam int CapW      = 16;
    localparam int PeriodW   = CapW + 1;
    localparam int TickW     = 27;
    localparam int FracBits  = 8;
    localparam int FreqW     = TickW + FracBits;
    localparam int DivSteps  = FreqW;
    localparam int StepCntW  = $clog2(DivSteps);

    localparam int DefNumChannels = 4;
    localparam int QueueDepth     = 2;

    localparam logic [TickW-1:0] TickRateReset = TickW'(1000000);

    typedef struct packed {
        logic [ChanW-1:0] channel;
        logic [CapW-1:0]  capture_value;
    } t_in_item;

    typedef struct packed {
        logic [ChanW-1:0]   result_channel;
        logic [PeriodW-1:0] period_ticks;
        logic [FreqW-1:0]   frequency_q8;
    } t_out_item;

    // Finished period measurement handed from front to back.
    typedef struct packed {
        logic [ChanW-1:0]   channel;
        logic [PeriodW-1:0] period;
    } t_meas;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage

FILE: src/cpfm_front.sv
module cpfm_front
    import cpfm_pkg::*;
#(
    parameter int NUM_CHANNELS = DefNumChannels
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_full,
    output logic     o_q_push,
    output t_meas    o_q_data
);

    localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0] r_pending;
    logic [CapW-1:0]         r_first [NUM_CHANNELS];

    logic [4:0]        w_ch_wide;
    logic              w_ch_ok;
    logic [ChIdxW-1:0] w_idx;
    logic              w_take;
    logic              w_second;
    logic [CapW-1:0]   w_diff;

    assign w_ch_wide = 5'(i_item.channel);
    assign w_ch_ok   = w_ch_wide < 5'(NUM_CHANNELS);
    assign w_idx     = w_ch_wide[ChIdxW-1:0];
    assign w_take    = i_push && !i_q_full && w_ch_ok;
    assign w_second  = r_pending[w_idx];
    assign w_diff    = i_item.capture_value - r_first[w_idx];

    assign o_full           = i_q_full;
    assign o_q_push         = w_take && w_second;
    assign o_q_data.channel = i_item.channel;
    // Equal captures mean one full counter wrap.
    assign o_q_data.period  = (w_diff == '0) ? {1'b1, {CapW{1'b0}}} : {1'b0, w_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_take) begin
            r_pending[w_idx] <= !w_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !w_second) begin
            r_first[w_idx] <= i_item.capture_value;
        end
    end

    a_pending_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_take) |->
            r_pending[$past(w_idx)] != $past(r_pending[w_idx]))
        else $error("channel phase did not toggle on an accepted capture");

endmodule

FILE: src/cpfm_queue.sv
module cpfm_queue
    import cpfm_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_meas i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_meas o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_meas           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_count == CntW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

FILE: src/cpfm_back.sv
module cpfm_back
    import cpfm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TickW-1:0] i_cfg_wdata,
    input  logic             i_q_empty,
    input  t_meas            i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output t_out_item        o_item
);

    t_back_state         r_state, n_state;
    logic [TickW-1:0]    r_tick, n_tick;
    logic [FreqW-1:0]    r_quo, n_quo;
    logic [PeriodW-1:0]  r_rem, n_rem;
    logic [PeriodW-1:0]  r_div, n_div;
    logic [ChanW-1:0]    r_ch, n_ch;
    logic [StepCntW-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic               w_out_pop;
    logic [PeriodW:0]   w_shift;
    logic [PeriodW:0]   w_sub;
    logic               w_qbit;

    assign w_out_pop = i_pop && r_out_valid;
    assign w_shift   = {r_rem, r_quo[FreqW-1]};
    assign w_sub     = w_shift - {1'b0, r_div};
    assign w_qbit    = w_shift >= {1'b0, r_div};

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_ch        = r_ch;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        if (i_cfg_we) begin
            n_tick = i_cfg_wdata;
        end
        if (w_out_pop) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_quo   = FreqW'({r_tick, {FracBits{1'b0}}});
                    n_rem   = '0;
                    n_div   = i_q_data.period;
                    n_ch    = i_q_data.channel;
                    n_cnt   = '0;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                // Restoring division, one quotient bit per cycle.
                n_rem = w_qbit ? w_sub[PeriodW-1:0] : w_shift[PeriodW-1:0];
                n_quo = {r_quo[FreqW-2:0], w_qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == StepCntW'(DivSteps - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                // Hold the quotient until the result slot frees.
                if (!r_out_valid || w_out_pop) begin
                    n_out.result_channel = r_ch;
                    n_out.period_ticks   = r_div;
                    n_out.frequency_q8   = r_quo;
                    n_out_valid          = 1'b1;
                    n_state              = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_tick      <= TickRateReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_ch  <= n_ch;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_RUN |-> r_rem < r_div)
        else $error("divider remainder not below divisor");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed before it was taken");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == BK_IDLE && !i_q_empty)
        else $error("queue popped outside idle");

endmodule

FILE: src/capture_period_frequency_meter_top.sv
// Input-capture period and frequency meter. Each item carries a channel and a
// 16-bit captured counter value; per channel, captures pair up: the first is
// stored, the second yields the period (difference modulo 65536, equal values
// count as 65536) and tick_rate_hz * 256 / period truncated. Items are accepted
// one per cycle while full is low; a two-entry queue holds finished periods for
// a bit-serial restoring divider, which loads a period, works out its 35-bit
// quotient bit by bit and hands the result to the output register. The divider
// takes a new period only once it has handed off the last one; full rises when
// two periods are waiting behind the divider. Write tick_rate_hz only while idle.
module capture_period_frequency_meter_top
    import cpfm_pkg::*;
#(
    parameter int NUM_CHANNELS = DefNumChannels
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_item,
    input  logic             i_cfg_we,
    input  logic [TickW-1:0] i_cfg_wdata
);

    logic  w_q_full;
    logic  w_q_push;
    t_meas w_q_wdata;
    logic  w_q_empty;
    logic  w_q_pop;
    t_meas w_q_rdata;

    cpfm_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_q_full(w_q_full),
        .o_full  (full),
        .o_q_push(w_q_push),
        .o_q_data(w_q_wdata)
    );

    cpfm_queue #(
        .DEPTH(QueueDepth)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data (w_q_wdata),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_empty(w_q_empty),
        .o_data (w_q_rdata)
    );

    cpfm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_item     (o_item)
    );

endmodule

FILE: tb/sv/cpfm_measurement_check.sv
module cpfm_measurement_check
    import cpfm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  logic             full,
    input  t_in_item         i_item,
    input  logic             empty,
    input  logic             pop,
    input  t_out_item        o_item,
    input  logic             i_cfg_we,
    input  logic [TickW-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumCh = DefNumChannels;

    logic [TickW-1:0] tick_rate;
    logic             second_due [NumCh];
    logic [CapW-1:0]  first_cap [NumCh];
    t_out_item        measurements_q [$];
    int               fails = 0;

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    function automatic logic [FreqW-1:0] q8_frequency(logic [TickW-1:0] rate,
                                                      logic [PeriodW-1:0] period);
        logic [FreqW-1:0] scaled;
        scaled = {rate, {FracBits{1'b0}}};
        return scaled / FreqW'(period);
    endfunction

    // First capture of a pair is stored; the second one completes a measurement.
    task automatic take_capture(t_in_item cap);
        logic [CapW-1:0]    diff;
        logic [PeriodW-1:0] period;
        t_out_item          m;
        if (!second_due[cap.channel]) begin
            first_cap[cap.channel]  = cap.capture_value;
            second_due[cap.channel] = 1'b1;
        end else begin
            second_due[cap.channel] = 1'b0;
            diff = cap.capture_value - first_cap[cap.channel];
            // equal captures span a full counter wrap
            period = (diff == '0) ? PeriodW'(1) << CapW : PeriodW'(diff);
            m.result_channel = cap.channel;
            m.period_ticks   = period;
            m.frequency_q8   = q8_frequency(tick_rate, period);
            measurements_q.push_back(m);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tick_rate = TickRateReset;
            for (int c = 0; c < NumCh; c++) begin
                second_due[c] = 1'b0;
                first_cap[c]  = '0;
            end
            measurements_q.delete();
        end else begin
            if (i_cfg_we) begin
                tick_rate = i_cfg_wdata;
            end
            if (push && !full) begin
                take_capture(i_item);
            end
            if (pop && !empty) begin
                if (measurements_q.size() == 0) begin
                    $error("unexpected result item: channel %0d period %0d freq %0d",
                           o_item.result_channel, o_item.period_ticks, o_item.frequency_q8);
                    fails++;
                end else begin
                    want = measurements_q.pop_front();
                    if (o_item.result_channel !== want.result_channel) begin
                        $error("result_channel: expected %0d, actual %0d",
                               want.result_channel, o_item.result_channel);
                        fails++;
                    end
                    if (o_item.period_ticks !== want.period_ticks) begin
                        $error("period_ticks: expected %0d, actual %0d",
                               want.period_ticks, o_item.period_ticks);
                        fails++;
                    end
                    if (o_item.frequency_q8 !== want.frequency_q8) begin
                        $error("frequency_q8: expected %0d, actual %0d",
                               want.frequency_q8, o_item.frequency_q8);
                        fails++;
                    end
                end
            end
        end
        o_waiting    <= measurements_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/capture_period_frequency_meter_top_test.sv
module capture_period_frequency_meter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpfm_pkg::*;

    localparam int NumCh       = DefNumChannels;
    localparam int DrainCycles = 48;
    localparam int StallLimit  = 2000;
    localparam int PhaseItems  = 75;
    localparam int NumPhases   = 8;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             push        = 1'b0;
    logic             pop         = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [TickW-1:0] i_cfg_wdata = '0;
    t_in_item         i_item      = '0;
    logic             full;
    logic             empty;
    t_out_item        o_item;
    int               fail_count;
    int               waiting;
    int               stall_cycles = 0;
    bit               quiet_sender   = 1'b0;
    bit               quiet_receiver = 1'b0;

    // track pairing only to shape captures, not to predict
    logic             armed [NumCh];
    logic [CapW-1:0]  last_cap [NumCh];

    always #5 i_clk = ~i_clk;

    capture_period_frequency_meter_top #(
        .NUM_CHANNELS(NumCh)
    ) dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_item,
        .empty,
        .pop,
        .o_item,
        .i_cfg_we,
        .i_cfg_wdata
    );

    cpfm_measurement_check u_meter_check (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_item,
        .empty,
        .pop,
        .o_item,
        .i_cfg_we,
        .i_cfg_wdata,
        .o_fail_count(fail_count),
        .o_waiting(waiting)
    );

    task automatic put_capture(logic [ChanW-1:0] ch, logic [CapW-1:0] value);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push                  <= 1'b1;
        i_item.channel        <= ch;
        i_item.capture_value  <= value;
        do @(posedge i_clk); while (full);
        armed[ch]    = ~armed[ch];
        last_cap[ch] = value;
    endtask

    // Hold the sender until every expected measurement has come out.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_tick_rate(logic [TickW-1:0] rate);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_capture();
        logic [ChanW-1:0] ch;
        logic [CapW-1:0]  value;
        ch    = ChanW'($urandom_range(0, NumCh - 1));
        value = CapW'($urandom);
        if (armed[ch]) begin
            case ($urandom_range(0, 9))
                0:       value = last_cap[ch];
                1:       value = last_cap[ch] + 1'b1;
                2:       value = last_cap[ch] - 1'b1;
                3, 4, 5: value = last_cap[ch] + CapW'($urandom_range(1, 255));
                default: ;
            endcase
        end
        put_capture(ch, value);
    endtask

    initial begin : receiver
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                gap = quiet_receiver ? 0 : $urandom_range(0, 8);
                if (gap != 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("capture_period_frequency_meter_top verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [TickW-1:0] rates [NumPhases];
        rates = '{TickRateReset, '0, TickW'(1), TickW'(100000000), '1,
                  TickW'($urandom_range(1, 100000000)),
                  TickW'($urandom_range(1, 100000000)),
                  TickW'($urandom_range(1, 5000))};
        for (int c = 0; c < NumCh; c++) begin
            armed[c]    = 1'b0;
            last_cap[c] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // interleaved pairs at the reset tick rate: full wrap, max and min periods
        put_capture(2'd0, 16'h0000);
        put_capture(2'd1, 16'h0000);
        put_capture(2'd2, 16'hFFFF);
        put_capture(2'd3, 16'hAAAA);
        put_capture(2'd3, 16'h5555);
        put_capture(2'd2, 16'h0000);
        put_capture(2'd1, 16'hFFFF);
        put_capture(2'd0, 16'h0000);
        // back-to-back pairs on one channel
        put_capture(2'd1, 16'd100);
        put_capture(2'd1, 16'd356);
        put_capture(2'd2, 16'h8000);
        put_capture(2'd2, 16'h7FFF);
        put_capture(2'd3, 16'h1234);
        put_capture(2'd3, 16'h1234);
        settle();

        for (int p = 0; p < NumPhases; p++) begin
            set_tick_rate(rates[p]);
            // period of one tick exposes the top of the frequency range
            put_capture(2'd0, 16'hFFFF);
            put_capture(2'd0, 16'h0000);
            for (int n = 0; n < PhaseItems; n++) begin
                if (n % 25 == 0) begin
                    quiet_sender   = ($urandom_range(0, 3) == 0);
                    quiet_receiver = ($urandom_range(0, 3) == 0);
                end
                random_capture();
            end
            settle();
        end

        if (fail_count == 0 && waiting == 0) begin
            $display("capture_period_frequency_meter_top verification clean");
        end else begin
            $display("capture_period_frequency_meter_top verification failed");
        end
        $finish;
    end

endmodule
